@@ src/lj_pkg.sv @@
package lj_pkg;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 4'd3;

  localparam logic [40:0] CLAMP40 = 41'h100_0000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] pos_i_x;
    logic signed [31:0] pos_i_y;
    logic signed [31:0] pos_i_z;
    logic signed [31:0] pos_j_x;
    logic signed [31:0] pos_j_y;
    logic signed [31:0] pos_j_z;
    logic [15:0]        neighbor_index;
  } operand_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] pair_energy;
    logic               in_range;
    logic               apply_to_neighbor;
  } result_t;

  // Per-item state that rides along the pipeline; fields fill in as stages finish.
  typedef struct packed {
    logic               cut;
    logic               far;
    logic               nbr;
    logic               zero;
    logic               ovl;
    logic               u_neg;
    logic               f_neg;
    logic               s_neg;
    logic signed [30:0] dx;
    logic signed [30:0] dy;
    logic signed [30:0] dz;
    logic [63:0]        d2;
    logic [31:0]        root;
    logic [63:0]        q;
    logic [63:0]        q3;
    logic signed [41:0] u;
    logic signed [31:0] en;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // floor(p / 2^32), saturating at 2^64-1
  function automatic logic [63:0] sat_hi(input logic [127:0] p);
    return (p[127:96] != 32'd0) ? '1 : p[95:32];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -44'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/lj_front.sv @@
module lj_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               cut,
  input  logic               nbr,
  input  lj_pkg::operand_t   operand,
  input  logic [31:0]        cutoff_sq,
  output logic               out_valid,
  output lj_pkg::item_t      out_item
);
  import lj_pkg::*;

  logic               v1, v2, v3;
  logic               c1, c2;
  logic               n1, n2;
  logic signed [32:0] dd1 [0:2];
  logic               far2;
  logic signed [30:0] ds2 [0:2];
  logic [59:0]        sq2 [0:2];
  item_t              it3;
  item_t              it3_next;

  logic [63:0] cut_d2;
  logic [61:0] sum;
  logic [63:0] d2;
  logic        far_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // diff = pos_j - pos_i
  always_ff @(posedge clk) begin
    c1     <= cut;
    n1     <= nbr;
    dd1[0] <= {operand.pos_j_x[31], operand.pos_j_x} - {operand.pos_i_x[31], operand.pos_i_x};
    dd1[1] <= {operand.pos_j_y[31], operand.pos_j_y} - {operand.pos_i_y[31], operand.pos_i_y};
    dd1[2] <= {operand.pos_j_z[31], operand.pos_j_z} - {operand.pos_i_z[31], operand.pos_i_z};
  end

  always_comb begin
    far_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (dd1[k] >= 33'sd1073741824 || dd1[k] <= -33'sd1073741824) begin
        far_hit = 1'b1;
      end
    end
  end

  // square each magnitude
  always_ff @(posedge clk) begin
    logic signed [32:0] m;
    c2   <= c1;
    n2   <= n1;
    far2 <= far_hit && !c1;
    for (int k = 0; k < 3; k++) begin
      m = (dd1[k] < 0) ? -dd1[k] : dd1[k];
      ds2[k] <= dd1[k][30:0];
      sq2[k] <= 60'(m[29:0]) * 60'(m[29:0]);
    end
  end

  assign cut_d2 = {4'd0, cutoff_sq, 28'd0};
  assign sum    = 62'(sq2[0]) + 62'(sq2[1]) + 62'(sq2[2]);
  assign d2     = c2 ? cut_d2 : {2'b00, sum};

  always_comb begin
    it3_next      = '0;
    it3_next.cut  = c2;
    it3_next.nbr  = n2;
    it3_next.far  = far2 || (!c2 && (d2 > cut_d2));
    it3_next.zero = (d2 == 64'd0);
    it3_next.dx   = ds2[0];
    it3_next.dy   = ds2[1];
    it3_next.dz   = ds2[2];
    it3_next.d2   = d2;
  end

  always_ff @(posedge clk) begin
    it3 <= it3_next;
  end

  assign out_valid = v3;
  assign out_item  = it3;

endmodule

@@ src/lj_sqrt.sv @@
module lj_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       x,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);
  localparam int STEPS = 32;

  logic              vld [0:STEPS];
  logic [63:0]       xs  [0:STEPS];
  logic [35:0]       rem [0:STEPS];
  logic [31:0]       rt  [0:STEPS];
  logic [SIDE_W-1:0] sd  [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    xs[0]  <= x;
    rem[0] <= '0;
    rt[0]  <= '0;
    sd[0]  <= side;
  end

  // one root bit per stage, two radicand bits brought down each time
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [35:0] remsh, trial;
    logic        ge;

    assign remsh = {rem[i][33:0], xs[i][63:62]};
    assign trial = {2'b00, rt[i], 2'b01};
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      xs[i+1]  <= {xs[i][61:0], 2'b00};
      rem[i+1] <= ge ? (remsh - trial) : remsh;
      rt[i+1]  <= {rt[i][30:0], ge};
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = rt[STEPS];
  assign side_out  = sd[STEPS];

endmodule

@@ src/lj_mul.sv @@
module lj_mul #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [127:0]      prod,
  output logic [SIDE_W-1:0] side_out
);
  logic              v1, v2;
  logic [63:0]       p00, p01, p10, p11;
  logic [127:0]      p2;
  logic [SIDE_W-1:0] s1, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // 32x32 partial products, then one merge stage
  always_ff @(posedge clk) begin
    p00 <= 64'(a[31:0])  * 64'(b[31:0]);
    p01 <= 64'(a[31:0])  * 64'(b[63:32]);
    p10 <= 64'(a[63:32]) * 64'(b[31:0]);
    p11 <= 64'(a[63:32]) * 64'(b[63:32]);
    s1  <= side;
    p2  <= {p11, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0};
    s2  <= s1;
  end

  assign out_valid = v2;
  assign prod      = p2;
  assign side_out  = s2;

endmodule

@@ src/lj_div.sv @@
module lj_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       n_hi,
  input  logic [63:0]       n_lo,
  input  logic [63:0]       den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [63:0]       quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);
  localparam int STEPS = 64;

  logic              vld [0:STEPS];
  logic [63:0]       rem [0:STEPS];
  logic [63:0]       lq  [0:STEPS];
  logic [63:0]       dv  [0:STEPS];
  logic              of  [0:STEPS];
  logic [SIDE_W-1:0] sd  [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= n_hi;
    lq[0]  <= n_lo;
    dv[0]  <= den;
    of[0]  <= (n_hi >= den);
    sd[0]  <= side;
  end

  // restoring division, one quotient bit per stage; quotient shifts in as dividend shifts out
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [64:0] r65, diff;
    logic        ge;

    assign r65  = {rem[i], lq[i][63]};
    assign diff = r65 - {1'b0, dv[i]};
    assign ge   = (r65 >= {1'b0, dv[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[63:0] : r65[63:0];
      lq[i+1]  <= {lq[i][62:0], ge};
      dv[i+1]  <= dv[i];
      of[i+1]  <= of[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[STEPS];
  assign quot      = lq[STEPS];
  assign ovf       = of[STEPS];
  assign side_out  = sd[STEPS];

endmodule

@@ src/lj_pair_force_shifted.sv @@
// Truncated and shifted 12-6 Lennard-Jones pair kernel. Pulse start with one particle
// pair on operand while busy is low; the item is taken on that edge. Every pair comes
// back exactly once, in order, on result for a single cycle with done high; the block
// never stalls, so the receiver must take each result when done is up. A new pair may
// enter every cycle while busy is low. The pipeline holds three 64-stage restoring
// dividers in series (sigma^2/r^2, the scalar force, the force components) plus a
// 32-stage square root and the 64-bit multiplier chain. After reset and after every
// register write, busy is high for one cycle while an internal item carrying the
// cutoff distance enters the pipeline; it refreshes the cutoff force and energy before
// any later pair needs them and gives no result. Write registers only while no pair is
// in flight.
module lj_pair_force_shifted #(
  parameter int MAX_PARTICLES = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  lj_pkg::operand_t             operand,
  output logic                         done,
  output lj_pkg::result_t              result,
  input  logic                         cfg_we,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);
  import lj_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  // configuration and derived constants
  logic [31:0]        epsilon_energy;
  logic [31:0]        sigma_length;
  logic [31:0]        cutoff_sq;
  logic [CNT_W-1:0]   real_particle_count;
  logic               pending;
  logic [63:0]        sigma_sq;
  logic [36:0]        eps24;
  logic signed [31:0] force_at_cutoff;
  logic signed [31:0] energy_at_cutoff;

  logic [16:0] cnt_in;
  logic        cfg_hit;
  logic        accept;
  logic        nbr;

  assign cnt_in = cfg_data[16:0];
  assign cfg_hit = cfg_we && (cfg_index == CFG_EPSILON || cfg_index == CFG_SIGMA ||
                              cfg_index == CFG_CUTOFF || cfg_index == CFG_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_energy      <= 32'd65536;
      sigma_length        <= 32'd65536;
      cutoff_sq           <= 32'd409600;
      real_particle_count <= '0;
      pending             <= 1'b1;
    end else begin
      // drop the refresh request once the cutoff item has gone in
      pending <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EPSILON: epsilon_energy <= cfg_data;
          CFG_SIGMA:   sigma_length   <= cfg_data;
          CFG_CUTOFF:  cutoff_sq      <= cfg_data;
          CFG_COUNT: begin
            if (32'(cnt_in) > 32'(MAX_PARTICLES)) begin
              real_particle_count <= CNT_W'(MAX_PARTICLES);
            end else begin
              real_particle_count <= CNT_W'(cnt_in);
            end
          end
          default: ;
        endcase
        if (cfg_hit) begin
          pending <= 1'b1;
        end
      end
    end
  end

  // settle long before the cutoff item reaches the dividers
  always_ff @(posedge clk) begin
    sigma_sq <= 64'(sigma_length) * 64'(sigma_length);
    eps24    <= 37'({epsilon_energy, 4'd0}) + 37'({epsilon_energy, 3'd0});
  end

  assign busy   = pending;
  assign accept = start && !busy;
  assign nbr    = 32'(operand.neighbor_index) < 32'(real_particle_count);

  // ---------------------------------------------------------------- diff and d2
  logic  fr_v;
  item_t fr_item;

  lj_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept || pending),
    .cut       (pending),
    .nbr       (nbr),
    .operand   (operand),
    .cutoff_sq (cutoff_sq),
    .out_valid (fr_v),
    .out_item  (fr_item)
  );

  // ---------------------------------------------------------------- r = isqrt(d2)
  logic              sq_v;
  logic [31:0]       sq_root;
  logic [ITEM_W-1:0] sq_side;
  item_t             sq_item;

  lj_sqrt #(.SIDE_W(ITEM_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_v),
    .x         (fr_item.d2),
    .side      (fr_item),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  always_comb begin
    sq_item      = sq_side;
    sq_item.root = sq_root;
  end

  // ---------------------------------------------------------------- q = sigma^2 / d2
  logic              qd_v;
  logic [63:0]       qd_quot;
  logic              qd_ovf;
  logic [ITEM_W-1:0] qd_side;
  item_t             q_item;

  lj_div #(.SIDE_W(ITEM_W)) u_div_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_v),
    .n_hi      ({20'd0, sigma_sq[63:20]}),
    .n_lo      ({sigma_sq[19:0], 44'd0}),
    .den       (sq_item.d2),
    .side      (sq_item),
    .out_valid (qd_v),
    .quot      (qd_quot),
    .ovf       (qd_ovf),
    .side_out  (qd_side)
  );

  always_comb begin
    q_item   = qd_side;
    q_item.q = qd_ovf ? '1 : qd_quot;
  end

  // ---------------------------------------------------------------- q^2, q^3, q^6
  logic              m1_v, m2_v, m3_v;
  logic [127:0]      m1_p, m2_p, m3_p;
  logic [ITEM_W-1:0] m1_side, m2_side, m3_side;
  item_t             m1_item, m2_item, m3_item;
  logic [63:0]       q2, q3;

  lj_mul #(.SIDE_W(ITEM_W)) u_mul_q2 (
    .clk (clk), .rst (rst), .in_valid (qd_v),
    .a (q_item.q), .b (q_item.q), .side (q_item),
    .out_valid (m1_v), .prod (m1_p), .side_out (m1_side)
  );

  assign m1_item = m1_side;
  assign q2      = sat_hi(m1_p);

  lj_mul #(.SIDE_W(ITEM_W)) u_mul_q3 (
    .clk (clk), .rst (rst), .in_valid (m1_v),
    .a (q2), .b (m1_item.q), .side (m1_item),
    .out_valid (m2_v), .prod (m2_p), .side_out (m2_side)
  );

  always_comb begin
    m2_item    = m2_side;
    q3         = sat_hi(m2_p);
    m2_item.q3 = q3;
  end

  lj_mul #(.SIDE_W(ITEM_W)) u_mul_q6 (
    .clk (clk), .rst (rst), .in_valid (m2_v),
    .a (q3), .b (q3), .side (m2_item),
    .out_valid (m3_v), .prod (m3_p), .side_out (m3_side)
  );

  assign m3_item = m3_side;

  // ---------------------------------------------------------------- |q6-q3|, |q3-2q6|
  logic        e_v;
  item_t       e_item;
  item_t       e_item_next;
  logic [63:0] e_m1, e_m2;
  logic        e_neg2;
  logic [63:0] q6, t2;
  logic        neg1, neg2;

  assign q6   = sat_hi(m3_p);
  assign t2   = {q6[62:0], 1'b0};
  assign neg1 = (q6 < m3_item.q3);
  assign neg2 = (m3_item.q3 < t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= m3_v;
    end
  end

  always_comb begin
    e_item_next       = m3_item;
    e_item_next.ovl   = q6[63];
    e_item_next.u_neg = neg1;
  end

  always_ff @(posedge clk) begin
    e_item <= e_item_next;
    e_m1   <= neg1 ? (m3_item.q3 - q6) : (q6 - m3_item.q3);
    e_m2   <= neg2 ? (t2 - m3_item.q3) : (m3_item.q3 - t2);
    e_neg2 <= neg2;
  end

  // ---------------------------------------------------------------- 4 eps m1, 24 eps m2
  logic              u_v;
  logic              fm_v;
  logic [127:0]      u_p, fm_p;
  logic [ITEM_W-1:0] u_side;
  logic              fm_neg;
  item_t             u_item;
  logic [63:0]       umag64;
  logic [40:0]       umag;

  lj_mul #(.SIDE_W(ITEM_W)) u_mul_u (
    .clk (clk), .rst (rst), .in_valid (e_v),
    .a ({30'd0, epsilon_energy, 2'b00}), .b (e_m1), .side (e_item),
    .out_valid (u_v), .prod (u_p), .side_out (u_side)
  );

  lj_mul #(.SIDE_W(1)) u_mul_f (
    .clk (clk), .rst (rst), .in_valid (e_v),
    .a ({27'd0, eps24}), .b (e_m2), .side (e_neg2),
    .out_valid (fm_v), .prod (fm_p), .side_out (fm_neg)
  );

  assign umag64 = sat_hi(u_p);
  assign umag   = (umag64 > 64'(CLAMP40)) ? CLAMP40 : umag64[40:0];

  always_comb begin
    u_item       = u_side;
    u_item.u     = u_item.u_neg ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
    u_item.f_neg = fm_neg;
  end

  // ---------------------------------------------------------------- dU/dr = 24 eps m2 / (r 2^10)
  logic              fd_v;
  logic [63:0]       fd_quot;
  logic              fd_ovf;
  logic [ITEM_W-1:0] fd_side;
  item_t             fd_item;

  lj_div #(.SIDE_W(ITEM_W)) u_div_f (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (u_v),
    .n_hi      (fm_p[127:64]),
    .n_lo      (fm_p[63:0]),
    .den       ({22'd0, u_item.root, 10'd0}),
    .side      (u_item),
    .out_valid (fd_v),
    .quot      (fd_quot),
    .ovf       (fd_ovf),
    .side_out  (fd_side)
  );

  assign fd_item = fd_side;

  // ---------------------------------------------------------------- shift by the cutoff values
  logic [40:0]        fmag;
  logic signed [41:0] fval;
  logic signed [42:0] s_val;
  logic signed [42:0] s_abs;
  logic               g_v;
  item_t              g_item;
  item_t              g_item_next;
  logic [41:0]        g_sm;

  assign fmag  = (fd_ovf || fd_quot > 64'(CLAMP40)) ? CLAMP40 : fd_quot[40:0];
  assign fval  = fd_item.f_neg ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
  assign s_val = 43'(fval) - 43'(force_at_cutoff);
  assign s_abs = (s_val < 0) ? -s_val : s_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else begin
      g_v <= fd_v;
    end
  end

  always_comb begin
    g_item_next       = fd_item;
    g_item_next.s_neg = (s_val < 0);
    g_item_next.en    = sat32(44'(fd_item.u) - 44'(energy_at_cutoff));
  end

  always_ff @(posedge clk) begin
    g_item <= g_item_next;
    g_sm   <= s_abs[41:0];
  end

  // capture the cutoff terms as the refresh item passes; pairs behind it see the new values
  always_ff @(posedge clk) begin
    if (rst) begin
      force_at_cutoff  <= '0;
      energy_at_cutoff <= '0;
    end else if (fd_v && fd_item.cut) begin
      if (epsilon_energy == 32'd0) begin
        force_at_cutoff  <= '0;
        energy_at_cutoff <= '0;
      end else if (fd_item.zero || fd_item.ovl) begin
        force_at_cutoff  <= Q_MIN;
        energy_at_cutoff <= Q_MAX;
      end else begin
        force_at_cutoff  <= sat32(44'(fval));
        energy_at_cutoff <= sat32(44'(fd_item.u));
      end
    end
  end

  // ---------------------------------------------------------------- components s * d_k / r
  logic signed [30:0] g_d   [0:2];
  logic [29:0]        g_da  [0:2];
  logic [127:0]       c_p   [0:2];
  logic               c_v;
  logic               c1_v, c2_v;
  logic [ITEM_W-1:0]  c_side;
  item_t              c_item;
  logic [1:0]         c_sgn1, c_sgn2;

  assign g_d[0] = g_item.dx;
  assign g_d[1] = g_item.dy;
  assign g_d[2] = g_item.dz;

  always_comb begin
    logic signed [30:0] m;
    for (int k = 0; k < 3; k++) begin
      m       = (g_d[k] < 0) ? -g_d[k] : g_d[k];
      g_da[k] = m[29:0];
    end
  end

  lj_mul #(.SIDE_W(ITEM_W)) u_mul_c0 (
    .clk (clk), .rst (rst), .in_valid (g_v),
    .a ({22'd0, g_sm}), .b ({34'd0, g_da[0]}), .side (g_item),
    .out_valid (c_v), .prod (c_p[0]), .side_out (c_side)
  );

  lj_mul #(.SIDE_W(2)) u_mul_c1 (
    .clk (clk), .rst (rst), .in_valid (g_v),
    .a ({22'd0, g_sm}), .b ({34'd0, g_da[1]}), .side ({g_d[1] < 0, g_d[1] == 0}),
    .out_valid (c1_v), .prod (c_p[1]), .side_out (c_sgn1)
  );

  lj_mul #(.SIDE_W(2)) u_mul_c2 (
    .clk (clk), .rst (rst), .in_valid (g_v),
    .a ({22'd0, g_sm}), .b ({34'd0, g_da[2]}), .side ({g_d[2] < 0, g_d[2] == 0}),
    .out_valid (c2_v), .prod (c_p[2]), .side_out (c_sgn2)
  );

  assign c_item = c_side;

  logic              o_v;
  logic              o1_v, o2_v;
  logic [63:0]       o_quot [0:2];
  logic              o_ovf  [0:2];
  logic [ITEM_W-1:0] o_side;
  item_t             o_item;
  logic [1:0]        o_sgn1, o_sgn2;

  lj_div #(.SIDE_W(ITEM_W)) u_div_c0 (
    .clk (clk), .rst (rst), .in_valid (c_v),
    .n_hi (c_p[0][127:64]), .n_lo (c_p[0][63:0]), .den ({32'd0, c_item.root}),
    .side (c_item),
    .out_valid (o_v), .quot (o_quot[0]), .ovf (o_ovf[0]), .side_out (o_side)
  );

  lj_div #(.SIDE_W(2)) u_div_c1 (
    .clk (clk), .rst (rst), .in_valid (c_v),
    .n_hi (c_p[1][127:64]), .n_lo (c_p[1][63:0]), .den ({32'd0, c_item.root}),
    .side (c_sgn1),
    .out_valid (o1_v), .quot (o_quot[1]), .ovf (o_ovf[1]), .side_out (o_sgn1)
  );

  lj_div #(.SIDE_W(2)) u_div_c2 (
    .clk (clk), .rst (rst), .in_valid (c_v),
    .n_hi (c_p[2][127:64]), .n_lo (c_p[2][63:0]), .den ({32'd0, c_item.root}),
    .side (c_sgn2),
    .out_valid (o2_v), .quot (o_quot[2]), .ovf (o_ovf[2]), .side_out (o_sgn2)
  );

  assign o_item = o_side;

  // ---------------------------------------------------------------- final select
  logic               o_dneg  [0:2];
  logic               o_dzero [0:2];
  logic signed [31:0] f_norm  [0:2];
  logic signed [31:0] f_ovl   [0:2];
  result_t            res_next;

  assign o_dneg[0]  = (o_item.dx < 0);
  assign o_dzero[0] = (o_item.dx == 0);
  assign o_dneg[1]  = o_sgn1[1];
  assign o_dzero[1] = o_sgn1[0];
  assign o_dneg[2]  = o_sgn2[1];
  assign o_dzero[2] = o_sgn2[0];

  always_comb begin
    logic [31:0] mag;
    for (int k = 0; k < 3; k++) begin
      // magnitude caps at 2^31; a positive result then clips to the largest value
      if (o_ovf[k] || o_quot[k] > 64'h8000_0000) begin
        mag = 32'h8000_0000;
      end else begin
        mag = o_quot[k][31:0];
      end
      if (o_item.s_neg != o_dneg[k]) begin
        f_norm[k] = -$signed(mag);
      end else if (mag > 32'h7fff_ffff) begin
        f_norm[k] = Q_MAX;
      end else begin
        f_norm[k] = $signed(mag);
      end
      // overlapping pair: push hard against the diff direction
      if (o_dzero[k]) begin
        f_ovl[k] = '0;
      end else if (o_dneg[k]) begin
        f_ovl[k] = Q_MAX;
      end else begin
        f_ovl[k] = Q_MIN;
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (!o_item.far) begin
      res_next.in_range          = 1'b1;
      res_next.apply_to_neighbor = o_item.nbr;
      if (epsilon_energy == 32'd0) begin
        res_next.pair_energy = '0;
      end else if (o_item.zero || o_item.ovl) begin
        res_next.pair_energy = Q_MAX;
        res_next.force_x     = f_ovl[0];
        res_next.force_y     = f_ovl[1];
        res_next.force_z     = f_ovl[2];
      end else begin
        res_next.pair_energy = o_item.en;
        res_next.force_x     = f_norm[0];
        res_next.force_y     = f_norm[1];
        res_next.force_z     = f_norm[2];
      end
    end
  end

  // hold the cutoff refresh item back from the result port
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= o_v && !o_item.cut;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // ---------------------------------------------------------------- checks
  a_write_refresh: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> busy)
    else $error("register write did not start a cutoff refresh");

  a_refresh_short: assert property (@(posedge clk) disable iff (rst)
    busy && !cfg_we |=> !busy)
    else $error("busy held past the refresh cycle");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    done && !result.in_range |->
      result.force_x == 0 && result.force_y == 0 && result.force_z == 0 &&
      result.pair_energy == 0 && !result.apply_to_neighbor)
    else $error("out-of-range pair gave a nonzero result");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    fm_v == u_v && c1_v == c_v && c2_v == c_v && o1_v == o_v && o2_v == o_v)
    else $error("parallel lanes out of step");

endmodule

@@ verif/lj_pair_force_shifted_tb.sv @@
`timescale 1ns / 100ps

module lj_pair_force_shifted_tb;
  import lj_pkg::*;

  // Write index that decodes to no register; the block must drop the write.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd12;

  localparam logic [63:0] FORCE_CAP = 64'h100_0000_0000;
  localparam logic [63:0] COMP_CAP = 64'h8000_0000;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint SPAN_MAX = 64'sd1 << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  operand_t operand = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EPSILON;
  logic [31:0] cfg_data = '0;

  // Local copy of the block's registers and its cutoff values.
  logic [63:0] eps_q, sigma_q, cutoff_q, count_q;
  longint force_cut, energy_cut;

  result_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  lj_pair_force_shifted u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // floor(a*b / 2^32), saturating at 2^64-1
  function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:96] != 32'd0) ? '1 : p[95:32];
  endfunction

  // floor(n / d), saturating at cap; d is never zero here
  function automatic logic [63:0] capped_div(input logic [127:0] n, input logic [63:0] d,
                                             input logic [63:0] cap);
    logic [127:0] quo;
    if (n[127:64] >= d) return cap;
    quo = n / {64'd0, d};
    return (quo[63:0] > cap) ? cap : quo[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Potential and its radial derivative at squared distance d2; returns 1 on overlap.
  function automatic bit lj_terms(input logic [63:0] d2, output longint u, output longint f);
    logic [63:0] s2, q, q2, q3, q6, m, t, mag, r;
    bit neg;
    u = 0;
    f = 0;
    s2 = sigma_q * sigma_q;
    q = capped_div({64'd0, s2} << 44, d2, '1);
    q2 = frac_mul(q, q);
    q3 = frac_mul(q2, q);
    q6 = frac_mul(q3, q3);
    if (q6[63]) return 1'b1;
    neg = q6 < q3;
    m = neg ? q3 - q6 : q6 - q3;
    mag = frac_mul(eps_q * 4, m);
    if (mag > FORCE_CAP) mag = FORCE_CAP;
    u = neg ? -longint'(mag) : longint'(mag);
    t = q6 << 1;
    neg = q3 < t;
    m = neg ? t - q3 : q3 - t;
    r = int_sqrt(d2);
    mag = capped_div({64'd0, eps_q * 24} * {64'd0, m}, r << 10, FORCE_CAP);
    f = neg ? -longint'(mag) : longint'(mag);
    return 1'b0;
  endfunction

  function automatic void refresh_cutoff();
    logic [63:0] d2c;
    longint u, f;
    d2c = cutoff_q << 28;
    if (eps_q == 0) begin
      energy_cut = 0;
      force_cut = 0;
    end else if (d2c == 0 || lj_terms(d2c, u, f)) begin
      energy_cut = 64'sd2147483647;
      force_cut = -64'sd2147483648;
    end else begin
      energy_cut = clip32(u);
      force_cut = clip32(f);
    end
  endfunction

  function automatic result_t predict_pair(input operand_t op);
    result_t res;
    longint d[3], fo[3], en, u, fr, s;
    logic [63:0] d2, sm, dm, r, mag;
    res = '0;
    d[0] = longint'($signed(op.pos_j_x)) - longint'($signed(op.pos_i_x));
    d[1] = longint'($signed(op.pos_j_y)) - longint'($signed(op.pos_i_y));
    d[2] = longint'($signed(op.pos_j_z)) - longint'($signed(op.pos_i_z));
    d2 = '0;
    for (int k = 0; k < 3; k++) begin
      if (d[k] >= SPAN_MAX || d[k] <= -SPAN_MAX) return res;
      d2 = d2 + 64'(d[k] * d[k]);
    end
    if (d2 > (cutoff_q << 28)) return res;
    fo[0] = 0;
    fo[1] = 0;
    fo[2] = 0;
    en = 0;
    if (eps_q == 0) begin
      en = 0;
    end else if (d2 == 0 || lj_terms(d2, u, fr)) begin
      // Overlap: energy pegs high, each force component pushes against its offset.
      en = 64'sd2147483647;
      for (int k = 0; k < 3; k++)
        fo[k] = d[k] > 0 ? -64'sd2147483648 : (d[k] < 0 ? 64'sd2147483647 : 0);
    end else begin
      s = fr - force_cut;
      sm = 64'(s < 0 ? -s : s);
      r = int_sqrt(d2);
      en = clip32(u - energy_cut);
      for (int k = 0; k < 3; k++) begin
        dm = 64'(d[k] < 0 ? -d[k] : d[k]);
        mag = capped_div({64'd0, sm} * {64'd0, dm}, r, COMP_CAP);
        if ((s < 0) != (d[k] < 0)) fo[k] = -longint'(mag);
        else fo[k] = (mag > 64'h7fff_ffff) ? 64'sd2147483647 : longint'(mag);
      end
    end
    res.force_x = fo[0][31:0];
    res.force_y = fo[1][31:0];
    res.force_z = fo[2][31:0];
    res.pair_energy = en[31:0];
    res.in_range = 1'b1;
    res.apply_to_neighbor = ({48'd0, op.neighbor_index} < count_q);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
      end else begin
        want = pending_q.pop_front();
        check_field("force_x", want.force_x, result.force_x);
        check_field("force_y", want.force_y, result.force_y);
        check_field("force_z", want.force_z, result.force_z);
        check_field("pair_energy", want.pair_energy, result.pair_energy);
        check_field("in_range", 32'(want.in_range), 32'(result.in_range));
        check_field("apply_to_neighbor", 32'(want.apply_to_neighbor),
                    32'(result.apply_to_neighbor));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lj_pair_force_shifted regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold start high until the block takes the item; leave start up for back-to-back.
  task automatic send_pair(input operand_t op);
    start <= 1'b1;
    operand <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_pair(op));
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and let every pair in flight come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    logic [16:0] c;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    // Hold off while the block refreshes its cutoff terms.
    while (busy) @(posedge clk);
    case (idx)
      CFG_EPSILON: eps_q = {32'd0, data};
      CFG_SIGMA:   sigma_q = {32'd0, data};
      CFG_CUTOFF:  cutoff_q = {32'd0, data};
      CFG_COUNT: begin
        c = data[16:0];
        count_q = (c > 17'd65536) ? 64'd65536 : {47'd0, c};
      end
      default: return;
    endcase
    refresh_cutoff();
  endtask

  function automatic operand_t make_pair(input longint dx, input longint dy, input longint dz,
                                         input logic [15:0] nbr);
    operand_t op;
    op.pos_i_x = $urandom;
    op.pos_i_y = $urandom;
    op.pos_i_z = $urandom;
    op.pos_j_x = op.pos_i_x + 32'(dx);
    op.pos_j_y = op.pos_i_y + 32'(dy);
    op.pos_j_z = op.pos_i_z + 32'(dz);
    op.neighbor_index = nbr;
    return op;
  endfunction

  function automatic longint rand_offset(input longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // Mostly pairs near the well with random content; a slice of far or wild pairs.
  function automatic operand_t random_pair();
    longint span;
    operand_t op;
    span = longint'(sigma_q) * 64 * 3;
    if (span > SPAN_MAX) span = SPAN_MAX;
    if (span < 64) span = 64;
    case ($urandom_range(0, 9))
      0: begin
        op = '0;
        op.pos_i_x = $urandom;
        op.pos_i_y = $urandom;
        op.pos_i_z = $urandom;
        op.pos_j_x = $urandom;
        op.pos_j_y = $urandom;
        op.pos_j_z = $urandom;
        op.neighbor_index = 16'($urandom);
      end
      1: op = make_pair(rand_offset(span), 0, 0, 16'($urandom));
      2: op = make_pair(rand_offset(64), rand_offset(64), rand_offset(64), 16'($urandom));
      default: op = make_pair(rand_offset(span), rand_offset(span), rand_offset(span),
                              16'($urandom));
    endcase
    return op;
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      if (!quiet && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 13));
      send_pair(random_pair());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  localparam longint ONE = 64'sd1 << 22;

  // Reset settings: sigma 1.0, cutoff 2.5, no real particles.
  task automatic test_reset_directed();
    operand_t op;
    send_pair(make_pair(0, 0, 0, 16'd0));                   // coincident
    send_pair(make_pair(1, 0, 0, 16'd0));                   // one step apart
    send_pair(make_pair(0, -1, 1, 16'hffff));
    send_pair(make_pair(ONE, 0, 0, 16'd5));                 // r = sigma
    send_pair(make_pair(0, -(ONE * 112 / 100), 0, 16'd5));  // near the minimum
    send_pair(make_pair(0, 0, ONE * 5 / 2, 16'd5));         // exactly on the cutoff
    send_pair(make_pair(-(ONE * 5 / 2), 0, 0, 16'd5));
    send_pair(make_pair(ONE * 5 / 2 + 1, 0, 0, 16'd5));     // just past the cutoff
    send_pair(make_pair(ONE, -ONE, ONE, 16'd1));
    send_pair(make_pair(SPAN_MAX - 1, 0, 0, 16'd1));        // largest in-span offset
    send_pair(make_pair(0, SPAN_MAX, 0, 16'd1));            // span limit
    op = '0;
    op.pos_i_x = Q_MIN;
    op.pos_j_x = Q_MAX;
    op.pos_i_y = Q_MAX;
    op.pos_j_y = Q_MIN;
    op.pos_i_z = Q_MAX;
    op.pos_j_z = Q_MAX;
    op.neighbor_index = 16'hffff;
    send_pair(op);
    op.pos_i_x = Q_MAX;
    op.pos_j_x = Q_MAX;
    op.pos_i_y = Q_MIN;
    op.pos_j_y = Q_MIN;
    op.pos_j_z = Q_MAX - 1;
    send_pair(op);
  endtask

  task automatic test_particle_count();
    write_reg(CFG_COUNT, 32'd65535);
    send_pair(make_pair(ONE, 0, 0, 16'd65534));
    send_pair(make_pair(ONE, 0, 0, 16'hffff));
    write_reg(CFG_COUNT, 32'd65536);
    send_pair(make_pair(ONE, 0, 0, 16'hffff));
    write_reg(CFG_COUNT, 32'hffff_ffff);                 // saturates to the maximum
    send_pair(make_pair(ONE, ONE, 0, 16'hffff));
    write_reg(CFG_COUNT, 32'd0);
    send_pair(make_pair(ONE, ONE, 0, 16'd0));
    write_reg(CFG_UNUSED, 32'hdead_beef);                  // ignored
    write_reg(CFG_COUNT, 32'd1);
    send_pair(make_pair(ONE, 0, ONE, 16'd0));
    send_pair(make_pair(ONE, 0, ONE, 16'd1));
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_EPSILON, 32'hffff_ffff);
    write_reg(CFG_SIGMA, 32'hffff_ffff);
    write_reg(CFG_CUTOFF, 32'hffff_ffff);
    random_run(20);
    send_pair(make_pair(SPAN_MAX - 1, SPAN_MAX - 1, SPAN_MAX - 1, 16'd0));
    write_reg(CFG_SIGMA, 32'd65536);
    random_run(20);
    write_reg(CFG_SIGMA, 32'd0);                           // potential vanishes
    random_run(15);
    write_reg(CFG_SIGMA, 32'd65536);
    write_reg(CFG_EPSILON, 32'd0);                         // zero well depth
    random_run(15);
    write_reg(CFG_EPSILON, 32'd65536);
    write_reg(CFG_CUTOFF, 32'd0);                          // degenerate cutoff
    send_pair(make_pair(0, 0, 0, 16'd0));
    send_pair(make_pair(1, 0, 0, 16'd0));
    write_reg(CFG_CUTOFF, 32'd1);                          // cutoff inside overlap
    send_pair(make_pair(ONE / 256, 0, 0, 16'd0));
    random_run(10);
  endtask

  task automatic test_random_settings();
    longint sig, rc, csq;
    for (int phase = 0; phase < 6; phase++) begin
      sig = longint'($urandom_range(32768, 196608));
      rc = sig * longint'($urandom_range(24, 48)) / 16;
      csq = (rc * rc) >> 16;
      if (csq > 64'sh0ffff_ffff) csq = 64'sh0ffff_ffff;
      write_reg(CFG_SIGMA, 32'(sig));
      write_reg(CFG_CUTOFF, 32'(csq));
      write_reg(CFG_EPSILON, (phase == 2) ? $urandom : $urandom_range(4096, 1 << 20));
      write_reg(CFG_COUNT, $urandom_range(0, 70000));
      if (phase == 5) begin
        // Final stretch runs at full rate.
        drain();
        quiet = 1'b1;
      end
      random_run(95);
    end
  endtask

  initial begin
    eps_q = 64'd65536;
    sigma_q = 64'd65536;
    cutoff_q = 64'd409600;
    count_q = 64'd0;
    refresh_cutoff();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_directed();
    test_particle_count();
    test_register_extremes();
    test_random_settings();
    drain();
    if (errors == 0) begin
      $display("lj_pair_force_shifted regression: pass");
    end else begin
      $display("lj_pair_force_shifted regression: fail");
    end
    $finish;
  end

endmodule
